// ----- src/ppts_pkg.sv -----
// ----------------------------------------------------------------------------
// Periodic priority task scheduler package
// Shared widths, operation codes and the control/status bundle between the
// sequencer and the datapath.
// ----------------------------------------------------------------------------
package ppts_pkg;

  localparam int MAX_TASKS = 16;
  localparam int IDX_W     = 4;
  localparam int CNT_W     = 5;
  localparam int TIME_W    = 16;
  localparam int PRIO_W    = 8;
  localparam int MODE_W    = 3;
  localparam int PER_IN_W  = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD      = 3'd0,
    MODE_SUSPEND  = 3'd1,
    MODE_RESUME   = 3'd2,
    MODE_TICK     = 3'd3,
    MODE_SELECT   = 3'd4,
    MODE_COMPLETE = 3'd5
  } mode_t;

  typedef struct packed {
    logic load;      // capture the accepted item
    logic start;     // first execution cycle of the item
    logic walk;      // table walk in progress
    logic out_load;  // move the result into the output register
  } ppts_cmd_t;

  typedef struct packed {
    logic is_walk;   // the captured operation needs a table walk
    logic walk_done; // all reads issued and the last entry processed
  } ppts_sts_t;

endpackage

// ----- src/ppts_ifs.sv -----
// ----------------------------------------------------------------------------
// Scheduler channel interfaces
// Request, result and configuration channels, each with valid/ready.
// ----------------------------------------------------------------------------
interface ppts_in_if;
  import ppts_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [IDX_W-1:0]  task_index;
  logic [PRIO_W-1:0] priority_req;
  logic [PER_IN_W-1:0] period;
  logic              start_suspended;

  modport source (output valid, mode, task_index, priority_req, period,
                  start_suspended, input ready);
  modport sink   (input valid, mode, task_index, priority_req, period,
                  start_suspended, output ready);
endinterface

interface ppts_out_if;
  import ppts_pkg::*;
  logic             valid;
  logic             ready;
  logic             op_ok;
  logic             found;
  logic [IDX_W-1:0] chosen_index;
  logic [CNT_W-1:0] task_count;

  modport source (output valid, op_ok, found, chosen_index, task_count,
                  input ready);
  modport sink   (input valid, op_ok, found, chosen_index, task_count,
                  output ready);
endinterface

interface ppts_cfg_if;
  import ppts_pkg::*;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- src/ppts_ctrl.sv -----
// ----------------------------------------------------------------------------
// Scheduler sequencer
// One-hot state machine that steps an item through capture, execution,
// table walk and hand-off to the output register.
// ----------------------------------------------------------------------------
module ppts_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  ppts_pkg::ppts_sts_t sts,
  output ppts_pkg::ppts_cmd_t cmd
);
  import ppts_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_START = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.load     = (state_r == ST_IDLE) && in_valid;
    cmd.start    = (state_r == ST_START);
    cmd.walk     = (state_r == ST_WALK);
    cmd.out_load = (state_r == ST_DONE) && slot_free;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_START;
      end
      ST_START: begin
        state_nxt = sts.is_walk ? ST_WALK : ST_DONE;
      end
      ST_WALK: begin
        if (sts.walk_done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A finished result waiting in the sequencer reaches the output next cycle
  // once the output register has room.
  a_done_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && slot_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("result not handed to output register");

  // While the output holds an untaken result, it must not be overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !cmd.out_load)
    else $error("output register overwritten while stalled");

  // The walk only starts from the execution cycle.
  a_walk_entry: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == ST_WALK) |-> $past(state_r == ST_START))
    else $error("table walk entered outside execution");

endmodule

// ----- src/ppts_dp.sv -----
// ----------------------------------------------------------------------------
// Scheduler datapath
// Task table memories, the limit register, the item capture registers, the
// table walk address generator and the result registers.
// ----------------------------------------------------------------------------
module ppts_dp (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ppts_pkg::ppts_cmd_t     cmd,
  output ppts_pkg::ppts_sts_t     sts,
  input  logic [ppts_pkg::MODE_W-1:0]   in_mode,
  input  logic [ppts_pkg::IDX_W-1:0]    in_task_index,
  input  logic [ppts_pkg::PRIO_W-1:0]   in_priority_req,
  input  logic [ppts_pkg::PER_IN_W-1:0] in_period,
  input  logic                    in_start_suspended,
  input  logic                    cfg_we,
  input  logic [ppts_pkg::CNT_W-1:0]    cfg_data,
  output logic                    res_op_ok,
  output logic                    res_found,
  output logic [ppts_pkg::IDX_W-1:0]    res_chosen_index,
  output logic [ppts_pkg::CNT_W-1:0]    res_task_count
);
  import ppts_pkg::*;

  // Task table.
  logic [TIME_W-1:0] per_mem [MAX_TASKS];
  logic [TIME_W-1:0] rem_mem [MAX_TASKS];
  logic [PRIO_W-1:0] pri_mem [MAX_TASKS];
  logic              sus_mem [MAX_TASKS];

  // Captured item.
  logic [MODE_W-1:0] mode_r;
  logic [IDX_W-1:0]  idx_r;
  logic [PRIO_W-1:0] pri_r;
  logic [TIME_W-1:0] per_r;
  logic              sus_r;

  logic [CNT_W-1:0]  limit_r, limit_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  eff_limit;

  // Walk control.
  logic [CNT_W-1:0]  walk_cnt_r, walk_cnt_nxt;
  logic [CNT_W-1:0]  walk_len_r, walk_len_nxt;
  logic [IDX_W-1:0]  addr_r, addr_nxt;
  logic              pend_r, pend_nxt;
  logic [IDX_W-1:0]  pend_addr_r, pend_addr_nxt;
  logic              rd_en;

  // Registered read data.
  logic [TIME_W-1:0] rd_per_r;
  logic [TIME_W-1:0] rd_rem_r;
  logic [PRIO_W-1:0] rd_pri_r;
  logic              rd_sus_r;

  // Result state.
  logic              ok_r, ok_nxt;
  logic              found_r, found_nxt;
  logic [IDX_W-1:0]  chosen_r, chosen_nxt;
  logic [PRIO_W-1:0] best_r, best_nxt;

  // Output register.
  logic              o_ok_r, o_found_r;
  logic [IDX_W-1:0]  o_chosen_r;
  logic [CNT_W-1:0]  o_count_r;

  // Write ports.
  logic              tbl_we;
  logic [IDX_W-1:0]  tbl_waddr;
  logic              rem_we;
  logic [IDX_W-1:0]  rem_waddr;
  logic [TIME_W-1:0] rem_wdata;
  logic              sus_we;
  logic [IDX_W-1:0]  sus_waddr;
  logic              sus_wdata;

  logic              add_fits;
  logic              idx_in_limit;
  logic              idx_in_use;

  assign eff_limit    = (limit_r < CNT_W'(MAX_TASKS)) ? limit_r : CNT_W'(MAX_TASKS);
  assign add_fits     = (count_r < eff_limit);
  assign idx_in_limit = ({1'b0, idx_r} < eff_limit);
  assign idx_in_use   = ({1'b0, idx_r} < count_r);

  assign sts.is_walk   = (mode_r == MODE_TICK) || (mode_r == MODE_SELECT) ||
                         (mode_r == MODE_COMPLETE);
  assign sts.walk_done = (walk_cnt_r >= walk_len_r) && !pend_r;

  assign rd_en = cmd.walk && (walk_cnt_r < walk_len_r);

  assign limit_nxt = cfg_we ? cfg_data : limit_r;

  always_comb begin
    count_nxt     = count_r;
    walk_cnt_nxt  = walk_cnt_r;
    walk_len_nxt  = walk_len_r;
    addr_nxt      = addr_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    ok_nxt        = ok_r;
    found_nxt     = found_r;
    chosen_nxt    = chosen_r;
    best_nxt      = best_r;
    tbl_we        = 1'b0;
    tbl_waddr     = count_r[IDX_W-1:0];
    rem_we        = 1'b0;
    rem_waddr     = count_r[IDX_W-1:0];
    rem_wdata     = per_r;
    sus_we        = 1'b0;
    sus_waddr     = count_r[IDX_W-1:0];
    sus_wdata     = sus_r;

    if (cmd.start) begin
      ok_nxt       = 1'b0;
      found_nxt    = 1'b0;
      chosen_nxt   = '0;
      walk_cnt_nxt = '0;
      walk_len_nxt = '0;
      addr_nxt     = '0;
      pend_nxt     = 1'b0;
      case (mode_r)
        MODE_ADD: begin
          if (add_fits) begin
            tbl_we     = 1'b1;
            rem_we     = 1'b1;
            sus_we     = 1'b1;
            chosen_nxt = count_r[IDX_W-1:0];
            count_nxt  = count_r + CNT_W'(1);
            ok_nxt     = 1'b1;
          end
        end
        MODE_SUSPEND, MODE_RESUME: begin
          if (idx_in_limit) begin
            sus_we    = 1'b1;
            sus_waddr = idx_r;
            sus_wdata = (mode_r == MODE_SUSPEND);
            ok_nxt    = 1'b1;
          end
        end
        MODE_TICK, MODE_SELECT: begin
          walk_len_nxt = count_r;
          ok_nxt       = 1'b1;
        end
        MODE_COMPLETE: begin
          addr_nxt     = idx_r;
          walk_len_nxt = idx_in_use ? CNT_W'(1) : '0;
          ok_nxt       = idx_in_use;
        end
        default: ;
      endcase
    end

    if (cmd.walk) begin
      pend_nxt = rd_en;
      if (rd_en) begin
        pend_addr_nxt = addr_r;
        addr_nxt      = addr_r + IDX_W'(1);
        walk_cnt_nxt  = walk_cnt_r + CNT_W'(1);
      end
      // Process the entry whose read data arrived this cycle.
      if (pend_r) begin
        case (mode_r)
          MODE_TICK: begin
            if (!rd_sus_r && rd_rem_r != '0) begin
              rem_we    = 1'b1;
              rem_waddr = pend_addr_r;
              rem_wdata = rd_rem_r - TIME_W'(1);
            end
          end
          MODE_SELECT: begin
            if (rd_rem_r == '0 && !rd_sus_r && (!found_r || best_r < rd_pri_r)) begin
              found_nxt  = 1'b1;
              chosen_nxt = pend_addr_r;
              best_nxt   = rd_pri_r;
            end
          end
          MODE_COMPLETE: begin
            rem_we    = 1'b1;
            rem_waddr = pend_addr_r;
            rem_wdata = rd_per_r;
          end
          default: ;
        endcase
      end
    end
  end

  // Table memories.
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      per_mem[tbl_waddr] <= per_r;
      pri_mem[tbl_waddr] <= pri_r;
    end
    if (rem_we) rem_mem[rem_waddr] <= rem_wdata;
    if (sus_we) sus_mem[sus_waddr] <= sus_wdata;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_per_r <= per_mem[addr_r];
      rd_rem_r <= rem_mem[addr_r];
      rd_pri_r <= pri_mem[addr_r];
      rd_sus_r <= sus_mem[addr_r];
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      idx_r  <= in_task_index;
      pri_r  <= in_priority_req;
      per_r  <= TIME_W'(in_period);
      sus_r  <= in_start_suspended;
    end
    if (cmd.out_load) begin
      o_ok_r     <= ok_r;
      o_found_r  <= found_r;
      o_chosen_r <= chosen_r;
      o_count_r  <= count_r;
    end
    pend_addr_r <= pend_addr_nxt;
    addr_r      <= addr_nxt;
    chosen_r    <= chosen_nxt;
    best_r      <= best_nxt;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r    <= CNT_W'(MAX_TASKS);
      count_r    <= '0;
      walk_cnt_r <= '0;
      walk_len_r <= '0;
      pend_r     <= 1'b0;
      ok_r       <= 1'b0;
      found_r    <= 1'b0;
    end else begin
      limit_r    <= limit_nxt;
      count_r    <= count_nxt;
      walk_cnt_r <= walk_cnt_nxt;
      walk_len_r <= walk_len_nxt;
      pend_r     <= pend_nxt;
      ok_r       <= ok_nxt;
      found_r    <= found_nxt;
    end
  end

  assign res_op_ok        = o_ok_r;
  assign res_found        = o_found_r;
  assign res_chosen_index = o_chosen_r;
  assign res_task_count   = o_count_r;

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_TASKS))
    else $error("task count above table size");

  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.start && mode_r == MODE_ADD && add_fits) |=>
      (count_r == $past(count_r) + CNT_W'(1)))
    else $error("accepted add did not grow the table");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    walk_cnt_r <= walk_len_r)
    else $error("table walk ran past its length");

endmodule

// ----- src/periodic_priority_task_scheduler_core.sv -----
// ----------------------------------------------------------------------------
// Periodic priority task scheduler core
// Keeps a table of periodic tasks and serves add, suspend, resume, tick,
// select and complete requests, one result per request.
// ----------------------------------------------------------------------------
// One request is handled at a time. Add, suspend, resume and unknown codes
// finish without a table walk. Tick and select walk the table through one
// memory read port, one entry per cycle, over every task in the table;
// complete reads only its own slot when the slot is in use and none if not.
// A new request is taken as soon as the previous result sits in the output
// register, even if that result has not been transferred yet. The table
// limit register may be written whenever no request is in flight.
module periodic_priority_task_scheduler_core (
  input  logic       clk,
  input  logic       rst_n,
  ppts_in_if.sink    in_ch,
  ppts_out_if.source out_ch,
  ppts_cfg_if.sink   cfg_ch
);
  import ppts_pkg::*;

  ppts_cmd_t cmd;
  ppts_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  ppts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ppts_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_mode            (in_ch.mode),
    .in_task_index      (in_ch.task_index),
    .in_priority_req    (in_ch.priority_req),
    .in_period          (in_ch.period),
    .in_start_suspended (in_ch.start_suspended),
    .cfg_we             (cfg_ch.valid),
    .cfg_data           (cfg_ch.data),
    .res_op_ok          (out_ch.op_ok),
    .res_found          (out_ch.found),
    .res_chosen_index   (out_ch.chosen_index),
    .res_task_count     (out_ch.task_count)
  );

endmodule
